FILE: rtl/core/csd_pkg.sv
`default_nettype none

package csd_pkg;

    // Directory dimensions.
    localparam int NUM_USERS  = 32;
    localparam int NUM_CHUNKS = 64;

    // IDs run from 1 up to this limit, capped by the 6-bit user fields.
    localparam int ID_LIMIT = (NUM_USERS < 63) ? NUM_USERS : 63;

    // Width of a holder row and of the active-user mask.
    localparam int UW  = ID_LIMIT;
    // Bits needed to index one user bit.
    localparam int UIW = $clog2(UW);
    // Bits needed to address one chunk row.
    localparam int CAW = $clog2(NUM_CHUNKS);

    // Fixed payload widths.
    localparam int USER_FW    = 6;
    localparam int CHUNK_FW   = 6;
    localparam int SHARERS_FW = 32;

    typedef enum logic [1:0] {
        ACT_JOIN  = 2'd0,
        ACT_LEAVE = 2'd1,
        ACT_REQ   = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_WR
    } state_t;

    typedef enum logic {
        ROW_SET,
        ROW_CLR
    } row_op_t;

    // Control bundle for the shared row update unit.
    typedef struct packed {
        row_op_t         op;
        logic            valid;
        logic [UW-1:0]   mask;
    } row_ctl_t;

    function automatic logic valid_user(input logic [USER_FW-1:0] u);
        return (u != '0) && (32'(u) <= 32'(ID_LIMIT));
    endfunction

    function automatic logic [UW-1:0] user_bit(input logic [USER_FW-1:0] u);
        logic [UW-1:0] one;
        one = UW'(1);
        return one << (u - USER_FW'(1));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/csd_ram.sv
`default_nettype none

module csd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/csd_row_alu.sv
`default_nettype none

module csd_row_alu
    import csd_pkg::*;
(
    input  wire logic [UW-1:0] rdata,
    input  wire row_ctl_t      ctl,
    output logic      [UW-1:0] cur_row,
    output logic      [UW-1:0] new_row
);

    // A row that was never written since reset holds no holders.
    assign cur_row = ctl.valid ? rdata : '0;

    always_comb
    begin
        case (ctl.op)
            ROW_SET: new_row = cur_row | ctl.mask;
            ROW_CLR: new_row = cur_row & ~ctl.mask;
            default: new_row = cur_row;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/csd_id_alloc.sv
`default_nettype none

module csd_id_alloc
    import csd_pkg::*;
(
    input  wire logic [UW-1:0]      active,
    output logic                    free_found,
    output logic [USER_FW-1:0]      free_id
);

    // Lowest clear bit wins, so the smallest free ID is handed out.
    always_comb
    begin
        free_id = '0;
        for (int i = UW - 1; i >= 0; i--)
        begin
            if (!active[i])
            begin
                free_id = USER_FW'(i + 1);
            end
        end
    end

    assign free_found = (free_id != '0);

endmodule

`default_nettype wire

FILE: rtl/core/chunk_sharer_directory.sv
// done pulses in the cycle after a transfer that touches no chunk row. A join item with a
// chunk or a request reads one row in ST_RD and may update it in ST_WR; a leave sweeps every
// row through the shared row unit in ST_RD/ST_WR pairs. done is registered from the last ST_WR.
// Throughput: one item at a time; start is taken again in the cycle that shows done.
// The receiver cannot stall: each result is flagged by done for exactly one cycle.
// Reset empties the directory at once by clearing the per-row valid bits; no clearing pass.
`default_nettype none

module chunk_sharer_directory
    import csd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            action,
    input  wire logic [USER_FW-1:0]    user,
    input  wire logic [CHUNK_FW-1:0]   chunk,
    input  wire logic                  has_chunk,
    input  wire logic                  last_of_list,
    output logic                       done,
    output logic [USER_FW-1:0]         user_id,
    output logic [SHARERS_FW-1:0]      sharers,
    output logic                       found,
    output logic                       full_res
);

    // -------------------------------------------------------------------------
    // State and registers
    // -------------------------------------------------------------------------
    // The holder matrix lives in a RAM with one row per chunk. Every row operation
    // is a read of one row followed by a write of the updated row (skipped for a request
    // that adds nobody), done by the shared row unit. A leave repeats that read/write pair over every row.
    state_t                 state_reg, state_next;
    action_t                op_reg, op_next;
    logic [CAW-1:0]         addr_reg, addr_next;
    logic [UW-1:0]          mask_reg, mask_next;
    logic                   req_add_reg, req_add_next;

    logic [UW-1:0]          active_reg, active_next;
    logic                   join_open_reg, join_open_next;
    logic [USER_FW-1:0]     joining_user_reg, joining_user_next;
    logic [NUM_CHUNKS-1:0]  row_valid_reg, row_valid_next;

    logic                   done_reg;
    logic [USER_FW-1:0]     user_id_reg, user_id_next;
    logic [SHARERS_FW-1:0]  sharers_reg, sharers_next;
    logic                   found_reg, found_next;
    logic                   full_reg, full_next;

    // -------------------------------------------------------------------------
    // Decode of the incoming transfer
    // -------------------------------------------------------------------------
    action_t                act;
    logic                   accept;
    logic                   chunk_ok;
    logic                   user_active;
    logic                   leave_ok;
    logic                   join_go;
    logic                   free_found;
    logic [USER_FW-1:0]     free_id;

    assign act      = action_t'(action);
    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign chunk_ok = (32'(chunk) < 32'(NUM_CHUNKS));

    assign user_active = valid_user(user) && ((active_reg & user_bit(user)) != '0);

    // A leave of the user whose join is still open is ignored.
    assign leave_ok = user_active && !(join_open_reg && (user == joining_user_reg));

    // A join proceeds when one is already open or a free ID can be taken.
    assign join_go = join_open_reg || free_found;

    csd_id_alloc u_alloc (
        .active     (active_reg),
        .free_found (free_found),
        .free_id    (free_id)
    );

    // -------------------------------------------------------------------------
    // Row storage and the shared row unit
    // -------------------------------------------------------------------------
    row_ctl_t               row_ctl;
    logic [UW-1:0]          rdata;
    logic [UW-1:0]          cur_row;
    logic [UW-1:0]          new_row;
    logic                   wr_en;
    logic                   finish;

    assign row_ctl.op    = (op_reg == ACT_LEAVE) ? ROW_CLR : ROW_SET;
    assign row_ctl.valid = row_valid_reg[addr_reg];
    assign row_ctl.mask  = mask_reg;

    csd_ram #(
        .WIDTH (UW),
        .DEPTH (NUM_CHUNKS)
    ) u_rows (
        .clk   (clk),
        .we    (wr_en),
        .waddr (addr_reg),
        .wdata (new_row),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    csd_row_alu u_alu (
        .rdata   (rdata),
        .ctl     (row_ctl),
        .cur_row (cur_row),
        .new_row (new_row)
    );

    // -------------------------------------------------------------------------
    // Sequencer: next state
    // -------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (act)
                        ACT_JOIN:
                        begin
                            if (join_go && has_chunk && chunk_ok)
                            begin
                                state_next = ST_RD;
                            end
                        end
                        ACT_LEAVE:
                        begin
                            if (leave_ok)
                            begin
                                state_next = ST_RD;
                            end
                        end
                        ACT_REQ:
                        begin
                            if (chunk_ok)
                            begin
                                state_next = ST_RD;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD: state_next = ST_WR;
            ST_WR:
            begin
                if ((op_reg == ACT_LEAVE) && (addr_reg != CAW'(NUM_CHUNKS - 1)))
                begin
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // -------------------------------------------------------------------------
    // Sequencer: outputs
    // -------------------------------------------------------------------------
    always_comb
    begin
        finish = 1'b0;
        wr_en  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                finish = accept && (state_next == ST_IDLE);
            end
            ST_WR:
            begin
                finish = (state_next == ST_IDLE);
                // A request only adds the requester to a row that already
                // had holders, and only for an active requester.
                if (op_reg == ACT_REQ)
                begin
                    wr_en = req_add_reg && (cur_row != '0);
                end
                else
                begin
                    wr_en = 1'b1;
                end
            end
            default:
            begin
                finish = 1'b0;
                wr_en  = 1'b0;
            end
        endcase
    end

    // -------------------------------------------------------------------------
    // Directory bookkeeping and result capture
    // -------------------------------------------------------------------------
    always_comb
    begin
        logic               jo;
        logic [USER_FW-1:0] jid;

        jo                = join_open_reg;
        jid               = joining_user_reg;
        op_next           = op_reg;
        addr_next         = addr_reg;
        mask_next         = mask_reg;
        req_add_next      = req_add_reg;
        active_next       = active_reg;
        join_open_next    = join_open_reg;
        joining_user_next = joining_user_reg;
        row_valid_next    = row_valid_reg;
        user_id_next      = user_id_reg;
        sharers_next      = sharers_reg;
        found_next        = found_reg;
        full_next         = full_reg;

        if (accept)
        begin
            op_next      = act;
            addr_next    = (act == ACT_LEAVE) ? '0 : CAW'(chunk);
            mask_next    = user_bit(user);
            req_add_next = 1'b0;
            user_id_next = '0;
            sharers_next = '0;
            found_next   = 1'b0;
            full_next    = 1'b0;
            case (act)
                ACT_JOIN:
                begin
                    // The first item of a join takes the smallest free ID.
                    if (!jo)
                    begin
                        if (free_found)
                        begin
                            jo          = 1'b1;
                            jid         = free_id;
                            active_next = active_reg | user_bit(free_id);
                        end
                        else
                        begin
                            full_next = 1'b1;
                        end
                    end
                    // The closing item returns the ID and ends the join.
                    if (jo && last_of_list)
                    begin
                        user_id_next = jid;
                        jo           = 1'b0;
                    end
                    join_open_next    = jo;
                    joining_user_next = jid;
                    mask_next         = user_bit(jid);
                end
                ACT_LEAVE:
                begin
                    if (leave_ok)
                    begin
                        active_next = active_reg & ~user_bit(user);
                    end
                end
                ACT_REQ:
                begin
                    req_add_next = user_active;
                end
                default:
                begin
                    req_add_next = 1'b0;
                end
            endcase
        end
        else if (state_reg == ST_WR)
        begin
            if (op_reg == ACT_REQ)
            begin
                sharers_next = SHARERS_FW'(cur_row);
                found_next   = (cur_row != '0);
            end
            if (op_reg == ACT_LEAVE)
            begin
                addr_next = addr_reg + CAW'(1);
            end
        end

        if (wr_en)
        begin
            row_valid_next[addr_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            op_reg           <= ACT_NONE;
            active_reg       <= '0;
            join_open_reg    <= 1'b0;
            joining_user_reg <= '0;
            row_valid_reg    <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            active_reg       <= active_next;
            join_open_reg    <= join_open_next;
            joining_user_reg <= joining_user_next;
            row_valid_reg    <= row_valid_next;
            done_reg         <= finish;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        mask_reg    <= mask_next;
        req_add_reg <= req_add_next;
        user_id_reg <= user_id_next;
        sharers_reg <= sharers_next;
        found_reg   <= found_next;
        full_reg    <= full_next;
    end

    assign done     = done_reg;
    assign user_id  = user_id_reg;
    assign sharers  = sharers_reg;
    assign found    = found_reg;
    assign full_res = full_reg;

    // -------------------------------------------------------------------------
    // Assertions
    // -------------------------------------------------------------------------
    logic [UIW-1:0] joining_idx;
    assign joining_idx = UIW'(joining_user_reg - USER_FW'(1));

    // An open join always owns an active ID.
    a_join_owns_id: assert property (@(posedge clk) disable iff (!rst_n)
        join_open_reg |-> (joining_user_reg != '0) && active_reg[joining_idx])
        else $error("open join without an active ID");

    // A result follows either a transfer that needs no row or the last write.
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_WR || (state_reg == ST_IDLE && start)))
        else $error("result strobe without a finishing step");

    // A full directory never returns an ID.
    a_full_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && full_reg) |-> (user_id_reg == '0))
        else $error("ID returned together with full flag");

    // The row sequencer only runs for real operations.
    a_rd_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |-> (op_reg != ACT_NONE))
        else $error("row access for an unused action");

endmodule

`default_nettype wire

FILE: tb/sv/tb_chunk_sharer_directory.sv
module tb_chunk_sharer_directory;
    timeunit 1ns;
    timeprecision 1ps;

    import csd_pkg::*;

    // Run length and limits. A leave sweeps every chunk row, so it is by far the
    // slowest operation. The cycle limit assumes every item is a leave that also
    // waits out the longest idle gap, and then allows several times that.
    localparam int RANDOM_ITEMS = 800;
    localparam int MAX_GAP      = 24;
    localparam int DRAIN_CYCLES = 2 * NUM_CHUNKS + 16;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int REPORT_CAP   = 40;

    // One input item as it waits in the backlog, with the idle gap that the
    // driver leaves before offering it.
    typedef struct {
        action_t                act;
        logic [USER_FW-1:0]     user;
        logic [CHUNK_FW-1:0]    chunk;
        logic                   has_chunk;
        logic                   last;
        int                     gap;
    } dir_item_t;

    // One result as the block should present it.
    typedef struct packed {
        logic [USER_FW-1:0]     user_id;
        logic [SHARERS_FW-1:0]  sharers;
        logic                   found;
        logic                   full_res;
    } dir_answer_t;

    // Traffic shapes for the random part: filling the directory up to the point
    // where joins are refused, emptying it again, or a balanced mixture.
    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } traffic_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [1:0]             action = ACT_JOIN;
    logic [USER_FW-1:0]     user = '0;
    logic [CHUNK_FW-1:0]    chunk = '0;
    logic                   has_chunk = 1'b0;
    logic                   last_of_list = 1'b0;
    logic                   done;
    logic [USER_FW-1:0]     user_id;
    logic [SHARERS_FW-1:0]  sharers;
    logic                   found;
    logic                   full_res;

    chunk_sharer_directory dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .user         (user),
        .chunk        (chunk),
        .has_chunk    (has_chunk),
        .last_of_list (last_of_list),
        .done         (done),
        .user_id      (user_id),
        .sharers      (sharers),
        .found        (found),
        .full_res     (full_res)
    );

    // Items still to be offered, and the results owed by the block, oldest first.
    dir_item_t   backlog[$];
    dir_answer_t pending_answers[$];
    dir_item_t   on_port;

    // Shadow copy of the directory: one holder row per chunk, the set of IDs in
    // use, and the join that is currently being assembled.
    logic [UW-1:0]      holders [NUM_CHUNKS];
    logic [UW-1:0]      active_set;
    logic               join_live;
    logic [USER_FW-1:0] join_id;

    int idle_pct = 18;
    int queued_items = 0;
    int items_sent = 0;
    int answers_checked = 0;
    int errors = 0;
    int full_refusals = 0;
    int leaves_done = 0;
    int shared_hits = 0;
    int cycles = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) cycles <= cycles + 1;

    task automatic report(input string msg);
        errors++;
        if (errors <= REPORT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Applies one accepted item to the shadow directory and returns the result
    // that the block owes for it.
    function automatic dir_answer_t directory_apply(input dir_item_t it);
        dir_answer_t   ans;
        logic [UW-1:0] ubit;
        logic [UW-1:0] row;
        int            id;
        int            u;
        int            c;
        ans = '0;
        // Only IDs 1 to ID_LIMIT have a bit; anything else can never be active.
        if (it.user != '0 && int'(it.user) <= ID_LIMIT)
            ubit = UW'(1) << (int'(it.user) - 1);
        else
            ubit = '0;
        case (it.act)
            ACT_JOIN: begin
                // The first item of a join claims the lowest free ID. If there
                // is none the item is refused outright and leaves no trace, so
                // the next join item starts afresh.
                if (!join_live) begin
                    id = 0;
                    for (u = ID_LIMIT; u >= 1; u--)
                        if (!active_set[u-1])
                            id = u;
                    if (id == 0) begin
                        ans.full_res = 1'b1;
                        full_refusals++;
                    end else begin
                        join_live = 1'b1;
                        join_id = USER_FW'(id);
                        active_set[id-1] = 1'b1;
                    end
                end
                if (join_live) begin
                    if (it.has_chunk && int'(it.chunk) < NUM_CHUNKS)
                        holders[it.chunk][int'(join_id) - 1] = 1'b1;
                    if (it.last) begin
                        ans.user_id = join_id;
                        join_live = 1'b0;
                    end
                end
            end
            ACT_LEAVE: begin
                // The user still being joined cannot leave half way through.
                if ((active_set & ubit) != '0 && !(join_live && it.user == join_id)) begin
                    for (c = 0; c < NUM_CHUNKS; c++)
                        holders[c] &= ~ubit;
                    active_set &= ~ubit;
                    leaves_done++;
                end
            end
            ACT_REQ: begin
                // The row is reported as it stood before the requester is added,
                // and an active requester only joins a chunk somebody already holds.
                if (int'(it.chunk) < NUM_CHUNKS) begin
                    row = holders[it.chunk];
                    ans.sharers = SHARERS_FW'(row);
                    ans.found = (row != '0);
                    if (row != '0) begin
                        shared_hits++;
                        if ((active_set & ubit) != '0)
                            holders[it.chunk] |= ubit;
                    end
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    // Driver. A transfer happens at an edge where start is high and busy is low;
    // the prediction is made there, from the item that was on the ports. The next
    // item goes out in the same edge unless its idle gap still has cycles to run.
    always @(posedge clk) begin : driver
        int c;
        if (!rst_n) begin
            for (c = 0; c < NUM_CHUNKS; c++)
                holders[c] = '0;
            active_set = '0;
            join_live = 1'b0;
            join_id = '0;
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                pending_answers.push_back(directory_apply(on_port));
                items_sent++;
            end
            if (!start || !busy) begin
                if (backlog.size() != 0 && backlog[0].gap == 0) begin
                    on_port = backlog.pop_front();
                    action <= on_port.act;
                    user <= on_port.user;
                    chunk <= on_port.chunk;
                    has_chunk <= on_port.has_chunk;
                    last_of_list <= on_port.last;
                    start <= 1'b1;
                end else begin
                    if (backlog.size() != 0)
                        backlog[0].gap = backlog[0].gap - 1;
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor. Every done strobe is one result transfer; it is matched against
    // the oldest outstanding prediction, field by field.
    always @(posedge clk) begin : monitor
        dir_answer_t want;
        if (rst_n && done) begin
            if (pending_answers.size() == 0) begin
                report($sformatf("result with nothing outstanding: user_id=%0d sharers=%h",
                                 user_id, sharers));
            end else begin
                want = pending_answers.pop_front();
                if (user_id !== want.user_id)
                    report($sformatf("result %0d user_id %0d, expected %0d",
                                     answers_checked, user_id, want.user_id));
                if (sharers !== want.sharers)
                    report($sformatf("result %0d sharers %h, expected %h",
                                     answers_checked, sharers, want.sharers));
                if (found !== want.found)
                    report($sformatf("result %0d found %b, expected %b",
                                     answers_checked, found, want.found));
                if (full_res !== want.full_res)
                    report($sformatf("result %0d full_res %b, expected %b",
                                     answers_checked, full_res, want.full_res));
                answers_checked++;
            end
        end
    end

    task automatic queue_item(input action_t act, input int u, input int ch,
                              input bit has, input bit last);
        dir_item_t it;
        it.act = act;
        it.user = USER_FW'(u);
        it.chunk = CHUNK_FW'(ch);
        it.has_chunk = has;
        it.last = last;
        it.gap = 0;
        while (it.gap < MAX_GAP && $urandom_range(99) < idle_pct)
            it.gap++;
        backlog.push_back(it);
        queued_items++;
    endtask

    // Mostly real IDs, so that leaves and requests tend to hit active users; now
    // and then zero or an ID beyond the directory.
    function automatic int pick_user();
        int r;
        r = $urandom_range(99);
        if (r < 88)
            return $urandom_range(ID_LIMIT, 1);
        else if (r < 94)
            return 0;
        else
            return $urandom_range(63, ID_LIMIT + 1);
    endfunction

    // A handful of popular chunks keeps the holder rows busy, so that requests
    // often find sharers and add themselves.
    function automatic int pick_chunk();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(7, 0);
        else if (r < 80)
            return $urandom_range(NUM_CHUNKS - 1, NUM_CHUNKS - 8);
        else
            return $urandom_range(NUM_CHUNKS - 1, 0);
    endfunction

    // A join of one to four items. Sometimes a leave or a request is slipped in
    // between two items of the list, which the block must serve on its own.
    task automatic queue_join();
        int len;
        int i;
        len = $urandom_range(4, 1);
        for (i = 0; i < len; i++) begin
            queue_item(ACT_JOIN, $urandom_range(63), pick_chunk(),
                       $urandom_range(99) < 85, i == len - 1);
            if (i < len - 1 && $urandom_range(99) < 10)
                queue_item($urandom_range(1) ? ACT_LEAVE : ACT_REQ, pick_user(),
                           pick_chunk(), 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    initial begin : sequencer
        traffic_mode_t mode;
        int random_base;
        int ops;
        int r;
        int join_lim;
        int leave_lim;
        int req_lim;

        // Directed part, with the directory starting empty.
        queue_item(ACT_REQ, 1, 0, 1'b0, 1'b0);       // request on an empty row
        queue_item(ACT_JOIN, 0, 0, 1'b0, 1'b1);      // join with an empty list gets ID 1
        queue_item(ACT_JOIN, 0, 0, 1'b1, 1'b0);      // two-item join: opens ID 2
        queue_item(ACT_JOIN, 0, 63, 1'b1, 1'b1);     // and closes it on the top chunk
        queue_item(ACT_REQ, 1, 0, 1'b0, 1'b0);       // user 1 finds user 2 and is added
        queue_item(ACT_REQ, 63, 63, 1'b1, 1'b1);     // requester out of range: not added
        queue_item(ACT_REQ, 0, 0, 1'b0, 1'b0);       // requester zero: not added
        queue_item(ACT_JOIN, 0, 42, 1'b1, 1'b0);     // opens ID 3
        queue_item(ACT_LEAVE, 3, 0, 1'b0, 1'b0);     // the joining user cannot leave yet
        queue_item(ACT_REQ, 3, 42, 1'b0, 1'b0);      // request inside an open join
        queue_item(ACT_JOIN, 0, 21, 1'b0, 1'b0);     // item without a chunk
        queue_item(ACT_JOIN, 0, 21, 1'b1, 1'b1);     // closes ID 3
        queue_item(ACT_LEAVE, 0, 0, 1'b0, 1'b0);     // leaves of IDs that cannot exist
        queue_item(ACT_LEAVE, 63, 63, 1'b1, 1'b1);
        queue_item(ACT_LEAVE, ID_LIMIT + 1, 0, 1'b0, 1'b0);
        queue_item(ACT_LEAVE, 9, 0, 1'b0, 1'b0);     // leave of an inactive user
        queue_item(ACT_NONE, 63, 63, 1'b1, 1'b1);    // unused action
        queue_item(ACT_LEAVE, 1, 0, 1'b0, 1'b0);     // user 1 goes, ID 1 is free again
        queue_item(ACT_REQ, 2, 0, 1'b0, 1'b0);       // only user 2 is left on chunk 0
        queue_item(ACT_JOIN, 0, 0, 1'b1, 1'b1);      // the freed ID 1 is handed out again
        queue_item(ACT_REQ, ID_LIMIT, 63, 1'b0, 1'b0); // highest ID, not active
        queue_item(ACT_LEAVE, 2, 0, 1'b0, 1'b0);
        queue_item(ACT_REQ, 3, 63, 1'b0, 1'b0);      // row now empty: nobody is added

        // Random part in segments of forty operations, each with its own traffic
        // shape. The sender's idling goes from light to heavy to none over the run.
        random_base = queued_items;
        ops = 0;
        mode = MODE_MIXED;
        while (queued_items - random_base < RANDOM_ITEMS) begin
            if (ops % 40 == 0) begin
                r = $urandom_range(9);
                mode = (r < 4) ? MODE_FILL : (r < 7) ? MODE_MIXED : MODE_DRAIN;
            end
            if (queued_items - random_base < RANDOM_ITEMS / 3)
                idle_pct = 18;
            else if (queued_items - random_base < 2 * RANDOM_ITEMS / 3)
                idle_pct = 67;
            else
                idle_pct = 0;
            case (mode)
                MODE_FILL: begin
                    join_lim = 70;
                    leave_lim = 80;
                end
                MODE_DRAIN: begin
                    join_lim = 15;
                    leave_lim = 70;
                end
                default: begin
                    join_lim = 35;
                    leave_lim = 60;
                end
            endcase
            req_lim = 98;
            r = $urandom_range(99);
            if (r < join_lim)
                queue_join();
            else if (r < leave_lim)
                queue_item(ACT_LEAVE, pick_user(), $urandom_range(63),
                           1'($urandom_range(1)), 1'($urandom_range(1)));
            else if (r < req_lim)
                queue_item(ACT_REQ, pick_user(), pick_chunk(),
                           1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                queue_item(ACT_NONE, $urandom_range(63), $urandom_range(63),
                           1'($urandom_range(1)), 1'($urandom_range(1)));
            ops++;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every item has been transferred and every result has come
        // back, then give a leave's worth of cycles for any stray strobe.
        do
            @(posedge clk);
        while (backlog.size() != 0 || start || pending_answers.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Transferred %0d items and checked %0d results with %0d mismatches.",
                 items_sent, answers_checked, errors);
        $display("Joins refused on a full directory: %0d, leaves applied: %0d, %s %0d.",
                 full_refusals, leaves_done, "requests that found holders:", shared_hits);
        if (errors == 0)
            $display("tb_chunk_sharer_directory: PASS");
        else
            $display("tb_chunk_sharer_directory: FAIL");
        $finish;
    end

    initial begin : watchdog
        wait (cycles >= CYCLE_LIMIT);
        $display("Cycle limit reached with %0d items transferred and %0d results checked.",
                 items_sent, answers_checked);
        $display("tb_chunk_sharer_directory: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/csd_pkg.sv
rtl/core/csd_ram.sv
rtl/core/csd_row_alu.sv
rtl/core/csd_id_alloc.sv
rtl/core/chunk_sharer_directory.sv
tb/sv/tb_chunk_sharer_directory.sv
